[src/undo_redo_history_stack_top_defines.svh]
`ifndef UNDO_REDO_HISTORY_STACK_TOP_DEFINES_SVH
`define UNDO_REDO_HISTORY_STACK_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define URHS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urhs assertion failed");

// next-cycle implication, checked out of reset
`define URHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urhs assertion failed");

`endif

[src/urhs_pkg.sv]
`default_nettype none

package urhs_pkg;

    localparam int URHS_DEPTH = 64;
    localparam int URHS_WIDTH = 64;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_UNDO = 2'd1,
        OP_REDO = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_NONE = 2'd2,
        ST_FULL = 2'd3
    } t_status;

endpackage

`default_nettype wire

[src/urhs_mem.sv]
`default_nettype none

module urhs_mem #(
    parameter int DEPTH = urhs_pkg::URHS_DEPTH,
    parameter int WIDTH = urhs_pkg::URHS_WIDTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/urhs_ctrl.sv]
`default_nettype none

`include "undo_redo_history_stack_top_defines.svh"

module urhs_ctrl #(
    parameter int DEPTH = urhs_pkg::URHS_DEPTH,
    parameter int WIDTH = urhs_pkg::URHS_WIDTH,
    localparam int AW   = $clog2(DEPTH),
    localparam int PW   = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [1:0]       i_operation,
    input  wire logic [WIDTH-1:0] i_value,
    output logic                  o_busy,
    output logic                  o_re,
    output logic      [AW-1:0]    o_raddr,
    input  wire logic [WIDTH-1:0] i_rdata,
    output logic                  o_we,
    output logic      [AW-1:0]    o_waddr,
    output logic      [WIDTH-1:0] o_wdata,
    output logic                  o_done,
    output logic      [WIDTH-1:0] o_value_out,
    output logic      [1:0]       o_status,
    output logic                  o_undo_available,
    output logic                  o_redo_available,
    output logic      [PW-1:0]    o_position
);

    logic             r_busy;
    logic [1:0]       r_op;
    logic [WIDTH-1:0] r_value;
    logic [PW-1:0]    r_cursor, n_cursor;
    logic [PW-1:0]    r_count,  n_count;
    logic             r_done;
    logic [WIDTH-1:0] r_value_out, n_value_out;
    logic [1:0]       r_status,    n_status;
    logic             accept;
    logic             we;
    logic [PW-1:0]    raddr_full;

    assign accept = i_start && !r_busy;

    // read address: current entry (cursor - 1) for push, landing entry for undo/redo
    always_comb begin
        case (i_operation)
            urhs_pkg::OP_PUSH: raddr_full = r_cursor - PW'(1);
            urhs_pkg::OP_UNDO: raddr_full = r_cursor - PW'(2);
            urhs_pkg::OP_REDO: raddr_full = r_cursor;
            default:           raddr_full = r_cursor;
        endcase
    end

    assign o_re    = accept;
    assign o_raddr = raddr_full[AW-1:0];

    // busy step: read data is back, decide and write
    always_comb begin
        n_cursor    = r_cursor;
        n_count     = r_count;
        n_value_out = '0;
        n_status    = urhs_pkg::ST_NONE;
        we          = 1'b0;
        case (r_op)
            urhs_pkg::OP_PUSH: begin
                if (r_cursor != '0 && i_rdata == r_value) begin
                    n_status = urhs_pkg::ST_DUP;
                end else if (r_cursor == PW'(DEPTH)) begin
                    n_status = urhs_pkg::ST_FULL;
                end else begin
                    we       = 1'b1;
                    n_cursor = r_cursor + PW'(1);
                    n_count  = r_cursor + PW'(1);
                    n_status = urhs_pkg::ST_DONE;
                end
            end
            urhs_pkg::OP_UNDO: begin
                if (r_cursor >= PW'(2)) begin
                    n_cursor    = r_cursor - PW'(1);
                    n_value_out = i_rdata;
                    n_status    = urhs_pkg::ST_DONE;
                end
            end
            urhs_pkg::OP_REDO: begin
                if (r_cursor < r_count) begin
                    n_cursor    = r_cursor + PW'(1);
                    n_value_out = i_rdata;
                    n_status    = urhs_pkg::ST_DONE;
                end
            end
            default: begin
                n_status = urhs_pkg::ST_NONE;
            end
        endcase
    end

    assign o_we    = r_busy && we;
    assign o_waddr = r_cursor[AW-1:0];
    assign o_wdata = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cursor <= '0;
            r_count  <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= r_busy;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy   <= 1'b0;
                r_cursor <= n_cursor;
                r_count  <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_value <= i_value;
        end
        if (r_busy) begin
            r_value_out <= n_value_out;
            r_status    <= n_status;
        end
    end

    assign o_busy           = r_busy;
    assign o_done           = r_done;
    assign o_value_out      = r_value_out;
    assign o_status         = r_status;
    assign o_undo_available = r_cursor >= PW'(2);
    assign o_redo_available = r_cursor < r_count;
    assign o_position       = r_cursor;

    `URHS_ASSERT_IMPL(a_cursor_le_count, i_clk, i_rst_n, 1'b1, r_cursor <= r_count)
    `URHS_ASSERT_IMPL(a_count_le_depth, i_clk, i_rst_n, 1'b1, r_count <= PW'(DEPTH))
    `URHS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_busy)
    `URHS_ASSERT_NEXT(a_busy_done, i_clk, i_rst_n, r_busy, r_done && !r_busy)
    `URHS_ASSERT_IMPL(a_write_push, i_clk, i_rst_n, o_we, r_busy && r_op == urhs_pkg::OP_PUSH)

endmodule

`default_nettype wire

[src/undo_redo_history_stack_top.sv]
`default_nettype none

// Undo/redo history stack with a cursor, entries held in one synchronous RAM.
// Command channel: an item (i_operation, i_value) is taken at a clock edge
// where start is high and busy is low. Operations: push, undo, redo.
// Each item has a read step, reading the RAM entry at or next to the cursor,
// then a busy step that compares, updates cursor and count, and writes a push.
// busy is high during the busy step, so no new item is taken until it ends.
// Result: o_done pulses for one cycle on the cycle after busy, carrying
// o_value_out, o_status, o_undo_available, o_redo_available and o_position.
// Results cannot be held off; the receiver must take each one as it comes.
// The result cycle overlaps the next item's read cycle.
// Reset (synchronous, active low) empties the history: position and count go
// to zero; RAM contents are left as they are and never used before written.
// A push equal to the entry at the cursor is ignored; a push on a full stack
// is refused; a failed undo or redo leaves the cursor in place.
module undo_redo_history_stack_top #(
    parameter int DEPTH = urhs_pkg::URHS_DEPTH,
    parameter int WIDTH = urhs_pkg::URHS_WIDTH,
    localparam int AW   = $clog2(DEPTH),
    localparam int PW   = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       i_operation,
    input  wire logic [WIDTH-1:0] i_value,
    output logic                  o_done,
    output logic      [WIDTH-1:0] o_value_out,
    output logic      [1:0]       o_status,
    output logic                  o_undo_available,
    output logic                  o_redo_available,
    output logic      [PW-1:0]    o_position
);

    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [WIDTH-1:0] mem_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [WIDTH-1:0] mem_wdata;

    urhs_ctrl #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_operation      (i_operation),
        .i_value          (i_value),
        .o_busy           (busy),
        .o_re             (mem_re),
        .o_raddr          (mem_raddr),
        .i_rdata          (mem_rdata),
        .o_we             (mem_we),
        .o_waddr          (mem_waddr),
        .o_wdata          (mem_wdata),
        .o_done           (o_done),
        .o_value_out      (o_value_out),
        .o_status         (o_status),
        .o_undo_available (o_undo_available),
        .o_redo_available (o_redo_available),
        .o_position       (o_position)
    );

    urhs_mem #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

[tb/sv/tb_undo_redo_history_stack_top.sv]
`default_nettype none

module tb_undo_redo_history_stack_top;
    timeunit 1ns;
    timeprecision 1ps;

    import urhs_pkg::*;

    localparam int DEPTH = URHS_DEPTH;
    localparam int WIDTH = URHS_WIDTH;
    localparam int PW = $clog2(DEPTH + 1);
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [WIDTH-1:0] ALL_ONES = '1;
    localparam int RANDOM_ITEMS = 1600;
    localparam int QUIET_TAIL = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [WIDTH-1:0] value_out;
        t_status          status;
        logic             undo_av;
        logic             redo_av;
        logic [PW-1:0]    position;
    } hist_result_t;

    typedef struct {
        logic [1:0]       op;
        logic [WIDTH-1:0] val;
        bit               typed;
        hist_result_t     exp;
    } dir_row_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic [1:0]       i_operation = OP_PUSH;
    logic [WIDTH-1:0] i_value = '0;
    logic             busy;
    logic             o_done;
    logic [WIDTH-1:0] o_value_out;
    logic [1:0]       o_status;
    logic             o_undo_available;
    logic             o_redo_available;
    logic [PW-1:0]    o_position;

    undo_redo_history_stack_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_value          (i_value),
        .o_done           (o_done),
        .o_value_out      (o_value_out),
        .o_status         (o_status),
        .o_undo_available (o_undo_available),
        .o_redo_available (o_redo_available),
        .o_position       (o_position)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [WIDTH-1:0] shadow_entries [DEPTH];
    int               shadow_pos = 0;
    int               shadow_count = 0;
    hist_result_t     expected_results [$];
    dir_row_t         directed_rows [$];
    int unsigned      fail_count = 0;
    int               stall_cycles = 0;

    function automatic hist_result_t predict_history_step(input logic [1:0] op,
                                                         input logic [WIDTH-1:0] val);
        hist_result_t r;
        r.value_out = '0;
        r.status = ST_NONE;
        case (op)
            OP_PUSH: begin
                if (shadow_pos > 0 && shadow_entries[shadow_pos-1] == val) begin
                    r.status = ST_DUP;
                end else if (shadow_pos >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_entries[shadow_pos] = val;
                    shadow_pos++;
                    shadow_count = shadow_pos;
                    r.status = ST_DONE;
                end
            end
            OP_UNDO: begin
                if (shadow_pos >= 2) begin
                    shadow_pos--;
                    r.value_out = shadow_entries[shadow_pos-1];
                    r.status = ST_DONE;
                end
            end
            OP_REDO: begin
                if (shadow_pos < shadow_count) begin
                    shadow_pos++;
                    r.value_out = shadow_entries[shadow_pos-1];
                    r.status = ST_DONE;
                end
            end
            default: ;
        endcase
        r.undo_av = (shadow_pos >= 2);
        r.redo_av = (shadow_pos < shadow_count);
        r.position = shadow_pos[PW-1:0];
        return r;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [WIDTH-1:0] val,
                           input bit typed, input logic [WIDTH-1:0] vout,
                           input t_status st, input logic u, input logic r,
                           input logic [PW-1:0] pos);
        dir_row_t row;
        row.op = op;
        row.val = val;
        row.typed = typed;
        row.exp = '{vout, st, u, r, pos};
        directed_rows.push_back(row);
    endtask

    task automatic send_item(input logic [1:0] op, input logic [WIDTH-1:0] val,
                             input bit typed, input hist_result_t typed_exp);
        hist_result_t predicted;
        start <= 1'b1;
        i_operation <= op;
        i_value <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = predict_history_step(op, val);
        expected_results.push_back(typed ? typed_exp : predicted);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (expected_results.size() != 0);
    endtask

    function automatic logic [WIDTH-1:0] pick_value(input bit fresh);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!fresh && roll < 25 && shadow_pos > 0)
            return shadow_entries[shadow_pos-1];
        if (!fresh && roll < 40)
            return WIDTH'($urandom_range(0, 3));
        if (roll < 50)
            return ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
        return {$urandom, $urandom};
    endfunction

    // mode 0 build, 1 fill toward full, 2 navigate, 3 push-only fill
    function automatic logic [1:0] pick_op(input int mode);
        int unsigned roll;
        int unsigned push_pct;
        int unsigned undo_pct;
        roll = $urandom_range(0, 99);
        case (mode)
            0: begin push_pct = 60; undo_pct = 20; end
            1: begin push_pct = 90; undo_pct = 5; end
            2: begin push_pct = 15; undo_pct = 40; end
            default: begin push_pct = 100; undo_pct = 0; end
        endcase
        if (roll < push_pct) return OP_PUSH;
        if (roll < push_pct + undo_pct) return OP_UNDO;
        if (roll < 96) return OP_REDO;
        return OP_RESERVED;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: value %h status %0d undo %0b redo %0b pos %0d",
                             o_value_out, o_status, o_undo_available,
                             o_redo_available, o_position);
            end else begin
                hist_result_t e;
                e = expected_results.pop_front();
                if (o_value_out !== e.value_out || o_status !== e.status ||
                    o_undo_available !== e.undo_av || o_redo_available !== e.redo_av ||
                    o_position !== e.position) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("mismatch exp: value %h status %0d undo %0b redo %0b pos %0d",
                                 e.value_out, e.status, e.undo_av, e.redo_av, e.position);
                        $display("         got: value %h status %0d undo %0b redo %0b pos %0d",
                                 o_value_out, o_status, o_undo_available,
                                 o_redo_available, o_position);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("undo_redo_history_stack_top verification failed");
            $finish;
        end
    end

    initial begin
        int sent;
        int seg_len;
        int mode;
        bit idle_on;
        logic [1:0] op;

        // empty history, then a short build with duplicates and redo drops
        add_row(OP_UNDO, '0, 1, '0, ST_NONE, 0, 0, 0);
        add_row(OP_REDO, '0, 1, '0, ST_NONE, 0, 0, 0);
        add_row(OP_RESERVED, ALL_ONES, 1, '0, ST_NONE, 0, 0, 0);
        add_row(OP_PUSH, '0, 1, '0, ST_DONE, 0, 0, 1);
        add_row(OP_PUSH, '0, 1, '0, ST_DUP, 0, 0, 1);
        add_row(OP_PUSH, ALL_ONES, 1, '0, ST_DONE, 1, 0, 2);
        add_row(OP_PUSH, ALL_ONES, 1, '0, ST_DUP, 1, 0, 2);
        add_row(OP_PUSH, 64'h5555_5555_5555_5555, 1, '0, ST_DONE, 1, 0, 3);
        add_row(OP_UNDO, '0, 1, ALL_ONES, ST_DONE, 1, 1, 2);
        add_row(OP_UNDO, '0, 1, '0, ST_DONE, 0, 1, 1);
        add_row(OP_UNDO, '0, 1, '0, ST_NONE, 0, 1, 1);
        add_row(OP_REDO, '0, 1, ALL_ONES, ST_DONE, 1, 1, 2);
        add_row(OP_RESERVED, 64'h1234, 1, '0, ST_NONE, 1, 1, 2);
        add_row(OP_REDO, '0, 1, 64'h5555_5555_5555_5555, ST_DONE, 1, 0, 3);
        add_row(OP_REDO, '0, 1, '0, ST_NONE, 1, 0, 3);
        add_row(OP_UNDO, '0, 1, ALL_ONES, ST_DONE, 1, 1, 2);
        add_row(OP_PUSH, '0, 1, '0, ST_DONE, 1, 0, 3);
        add_row(OP_REDO, '0, 1, '0, ST_NONE, 1, 0, 3);
        add_row(OP_PUSH, '0, 1, '0, ST_DUP, 1, 0, 3);
        add_row(OP_PUSH, 64'h1, 0, '0, ST_DONE, 0, 0, 0);
        add_row(OP_PUSH, 64'h8000_0000_0000_0000, 0, '0, ST_DONE, 0, 0, 0);
        add_row(OP_UNDO, '0, 0, '0, ST_DONE, 0, 0, 0);
        add_row(OP_UNDO, '0, 0, '0, ST_DONE, 0, 0, 0);
        add_row(OP_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 0, '0, ST_DONE, 0, 0, 0);
        add_row(OP_REDO, '0, 0, '0, ST_DONE, 0, 0, 0);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k])
            send_item(directed_rows[k].op, directed_rows[k].val,
                      directed_rows[k].typed, directed_rows[k].exp);
        drain_results();

        sent = 0;
        mode = 3;
        while (sent < RANDOM_ITEMS) begin
            seg_len = (mode == 3) ? 70 : $urandom_range(20, 80);
            idle_on = ($urandom_range(0, 2) != 0);
            repeat (seg_len) begin
                if (sent < RANDOM_ITEMS) begin
                    if (idle_on && sent < RANDOM_ITEMS - QUIET_TAIL &&
                        $urandom_range(0, 3) == 0) begin
                        start <= 1'b0;
                        repeat ($urandom_range(1, 15)) @(negedge i_clk);
                    end
                    op = pick_op(mode);
                    send_item(op, pick_value(mode == 3), 0, '0);
                    sent++;
                    if (sent == RANDOM_ITEMS / 2)
                        drain_results();
                end
            end
            if (sent < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
                drain_results();
            mode = $urandom_range(0, 3);
        end

        drain_results();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0)
            $display("undo_redo_history_stack_top verification clean");
        else
            $display("undo_redo_history_stack_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire
